/* design/vtvp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vtvp_pkg: shared definitions for the video timing and VRAM port
// Command codes, register addresses, status bits and default timing values.
// ----------------------------------------------------------------------------
package vtvp_pkg;

   // Command codes carried by one beat on the request channel.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Default timing, in dots and lines.
   localparam int DOTS_PER_LINE_DEF   = 340;
   localparam int VBLANK_LINE_DEF     = 225;
   localparam int LINES_PER_FRAME_DEF = 260;

   localparam int CNT_W   = 9;
   localparam int WADDR_W = 15;
   localparam int PAL_W   = 9;

   // Register addresses.
   localparam logic [15:0] ADDR_PORT_CTRL = 16'h2115;
   localparam logic [15:0] ADDR_WADDR_LO  = 16'h2116;
   localparam logic [15:0] ADDR_WADDR_HI  = 16'h2117;
   localparam logic [15:0] ADDR_VDATA_LO  = 16'h2118;
   localparam logic [15:0] ADDR_VDATA_HI  = 16'h2119;
   localparam logic [15:0] ADDR_PAL_ADDR  = 16'h2121;
   localparam logic [15:0] ADDR_PAL_DATA  = 16'h2122;
   localparam logic [15:0] ADDR_INT_EN    = 16'h4200;
   localparam logic [15:0] ADDR_VBL_STAT  = 16'h4210;
   localparam logic [15:0] ADDR_HV_STAT   = 16'h4212;

   // Status byte pieces.
   localparam logic [7:0] STAT_VBLANK   = 8'h80;
   localparam logic [7:0] STAT_HBLANK   = 8'h40;
   localparam logic [7:0] OPEN_BUS_MASK = 8'h70;

   // Horizontal blank window bounds.
   localparam logic [CNT_W-1:0] HBLANK_START = 9'h121;
   localparam logic [CNT_W-1:0] HBLANK_END   = 9'h015;

   // Address step choices.
   localparam logic [1:0] STEP_SEL_1  = 2'd0;
   localparam logic [1:0] STEP_SEL_32 = 2'd1;
   localparam logic [7:0] STEP_1      = 8'd1;
   localparam logic [7:0] STEP_32     = 8'd32;
   localparam logic [7:0] STEP_128    = 8'd128;

   // One result beat.
   typedef struct packed {
      logic [7:0]       read_data;
      logic             nmi_pulse;
      logic             frame_done;
      logic             vram_we;
      logic [15:0]      vram_byte_addr;
      logic             cgram_we;
      logic [PAL_W-1:0] cgram_byte_addr;
      logic [7:0]       mem_wdata;
   } rsp_type;

endpackage
`default_nettype wire

/* design/video_timing_and_vram_port.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// video_timing_and_vram_port: dot/line timing with a VRAM and palette bus port
// Counts dots and lines, flags vertical blank, serves the status reads and
// turns data-register writes into byte writes for external video memories.
// ----------------------------------------------------------------------------
// Usage
// Each request beat is a dot tick, a bus write or a bus read (req_cmd), with
// a register address and a write byte. Every request beat yields exactly one
// response beat, in order, carrying the status byte of a read, the frame and
// interrupt pulses of a tick, and at most one byte write towards VRAM or
// CGRAM.
// An accepted beat is registered in the main response register, or in the
// skid register while that one is held. Throughput is one beat per cycle
// while req_stall is low; all work is a few compares and adds (up to 15 bits)
// between the counter registers and the response register. The response side
// has a main register and a skid register, so a request is still taken while
// one finished response waits; req_stall rises only when both are full, and
// comes straight from a register. Reset (synchronous, active high) clears the
// counters, flags and addresses, sets the address step to one and empties both
// response registers. While rsp_stall is high the port response holds steady.
// ----------------------------------------------------------------------------
module video_timing_and_vram_port #(
   parameter int DOTS_PER_LINE   = vtvp_pkg::DOTS_PER_LINE_DEF,
   parameter int VBLANK_LINE     = vtvp_pkg::VBLANK_LINE_DEF,
   parameter int LINES_PER_FRAME = vtvp_pkg::LINES_PER_FRAME_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [15:0] req_bus_addr,
   input  wire logic [7:0]  req_wdata,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_nmi_pulse,
   output logic             rsp_frame_done,
   output logic             rsp_vram_we,
   output logic [15:0]      rsp_vram_byte_addr,
   output logic             rsp_cgram_we,
   output logic [8:0]       rsp_cgram_byte_addr,
   output logic [7:0]       rsp_mem_wdata
);

   localparam int CW = vtvp_pkg::CNT_W;
   localparam int AW = vtvp_pkg::WADDR_W;
   localparam int PW = vtvp_pkg::PAL_W;

   localparam logic [CW-1:0] DOTS_C   = CW'(DOTS_PER_LINE);
   localparam logic [CW-1:0] VBLANK_C = CW'(VBLANK_LINE);
   localparam logic [CW-1:0] LINES_C  = CW'(LINES_PER_FRAME);

   // Architectural state.
   logic [CW-1:0] dot_count_ff, dot_count_in;
   logic [CW-1:0] line_count_ff, line_count_in;
   logic          vblank_flag_ff, vblank_flag_in;
   logic          nmi_enable_ff, nmi_enable_in;
   logic [AW-1:0] vram_word_addr_ff, vram_word_addr_in;
   logic [7:0]    step_size_ff, step_size_in;
   logic          step_on_high_ff, step_on_high_in;
   logic [PW-1:0] palette_addr_ff, palette_addr_in;

   // Response registers: main stage and skid stage.
   vtvp_pkg::rsp_type rsp_ff, skid_ff, rsp_in;
   logic              rsp_valid_ff, skid_valid_ff;

   logic          accept;
   logic          take;
   logic          dot_wrap;
   logic [CW-1:0] line_next;
   logic [AW-1:0] vram_addr_stepped;

   // A request is taken whenever the skid stage is free.
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   assign dot_wrap          = (dot_count_ff == DOTS_C);
   assign line_next         = line_count_ff + CW'(1);
   assign vram_addr_stepped = vram_word_addr_ff + AW'(step_size_ff);

   // Work out the response and the next state for the beat on the port.
   always_comb begin
      dot_count_in      = dot_count_ff;
      line_count_in     = line_count_ff;
      vblank_flag_in    = vblank_flag_ff;
      nmi_enable_in     = nmi_enable_ff;
      vram_word_addr_in = vram_word_addr_ff;
      step_size_in      = step_size_ff;
      step_on_high_in   = step_on_high_ff;
      palette_addr_in   = palette_addr_ff;
      rsp_in            = '0;

      case (req_cmd)
         vtvp_pkg::CMD_TICK: begin
            // At the end of a line the dot count restarts and the line moves
            // on; entering the vblank line raises the flag, the frame pulse and,
            // if enabled, the interrupt pulse; reaching the frame length wraps
            // back to line zero. When both lines coincide the flag is set and
            // cleared in the same tick, but the pulses still go out.
            if (dot_wrap) begin
               line_count_in = line_next;
               if (line_next == VBLANK_C) begin
                  vblank_flag_in    = 1'b1;
                  rsp_in.frame_done = 1'b1;
                  rsp_in.nmi_pulse  = nmi_enable_ff;
               end
               if (line_next == LINES_C) begin
                  vblank_flag_in = 1'b0;
                  line_count_in  = '0;
               end
            end
            dot_count_in = (dot_wrap ? CW'(0) : dot_count_ff) + CW'(1);
         end
         vtvp_pkg::CMD_WRITE: begin
            case (req_bus_addr)
               vtvp_pkg::ADDR_PORT_CTRL: begin
                  case (req_wdata[1:0])
                     vtvp_pkg::STEP_SEL_1:  step_size_in = vtvp_pkg::STEP_1;
                     vtvp_pkg::STEP_SEL_32: step_size_in = vtvp_pkg::STEP_32;
                     default:               step_size_in = vtvp_pkg::STEP_128;
                  endcase
                  step_on_high_in = req_wdata[7];
               end
               vtvp_pkg::ADDR_WADDR_LO: begin
                  vram_word_addr_in = {vram_word_addr_ff[AW-1:8], req_wdata};
               end
               vtvp_pkg::ADDR_WADDR_HI: begin
                  vram_word_addr_in = {req_wdata[6:0], vram_word_addr_ff[7:0]};
               end
               vtvp_pkg::ADDR_VDATA_LO: begin
                  rsp_in.vram_we        = 1'b1;
                  rsp_in.vram_byte_addr = {vram_word_addr_ff, 1'b0};
                  rsp_in.mem_wdata      = req_wdata;
                  if (!step_on_high_ff) begin
                     vram_word_addr_in = vram_addr_stepped;
                  end
               end
               vtvp_pkg::ADDR_VDATA_HI: begin
                  rsp_in.vram_we        = 1'b1;
                  rsp_in.vram_byte_addr = {vram_word_addr_ff, 1'b1};
                  rsp_in.mem_wdata      = req_wdata;
                  if (step_on_high_ff) begin
                     vram_word_addr_in = vram_addr_stepped;
                  end
               end
               vtvp_pkg::ADDR_PAL_ADDR: begin
                  palette_addr_in = {req_wdata, 1'b0};
               end
               vtvp_pkg::ADDR_PAL_DATA: begin
                  rsp_in.cgram_we        = 1'b1;
                  rsp_in.cgram_byte_addr = palette_addr_ff;
                  rsp_in.mem_wdata       = req_wdata;
                  palette_addr_in        = palette_addr_ff + PW'(1);
               end
               vtvp_pkg::ADDR_INT_EN: begin
                  nmi_enable_in = req_wdata[7];
               end
               default: begin
               end
            endcase
         end
         vtvp_pkg::CMD_READ: begin
            case (req_bus_addr)
               vtvp_pkg::ADDR_VBL_STAT: begin
                  // The open-bus bits come from the high byte of the address.
                  rsp_in.read_data = (vblank_flag_ff ? vtvp_pkg::STAT_VBLANK : 8'h00)
                                   | (vtvp_pkg::ADDR_VBL_STAT[15:8]
                                      & vtvp_pkg::OPEN_BUS_MASK);
               end
               vtvp_pkg::ADDR_HV_STAT: begin
                  rsp_in.read_data =
                     ((line_count_ff >= VBLANK_C) ? vtvp_pkg::STAT_VBLANK : 8'h00)
                   | (((dot_count_ff >= vtvp_pkg::HBLANK_START)
                       || (dot_count_ff <= vtvp_pkg::HBLANK_END))
                      ? vtvp_pkg::STAT_HBLANK : 8'h00);
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // State registers move only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_count_ff      <= '0;
         line_count_ff     <= '0;
         vblank_flag_ff    <= 1'b0;
         nmi_enable_ff     <= 1'b0;
         vram_word_addr_ff <= '0;
         step_size_ff      <= vtvp_pkg::STEP_1;
         step_on_high_ff   <= 1'b0;
         palette_addr_ff   <= '0;
      end else if (accept) begin
         dot_count_ff      <= dot_count_in;
         line_count_ff     <= line_count_in;
         vblank_flag_ff    <= vblank_flag_in;
         nmi_enable_ff     <= nmi_enable_in;
         vram_word_addr_ff <= vram_word_addr_in;
         step_size_ff      <= step_size_in;
         step_on_high_ff   <= step_on_high_in;
         palette_addr_ff   <= palette_addr_in;
      end
   end

   // Response valid flags. The skid stage only fills while the main stage
   // is held, and drains into the main stage as soon as that one is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || take) begin
         rsp_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Response payload, no reset needed.
   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (accept) begin
            rsp_ff <= rsp_in;
         end
      end else if (accept) begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_ff.read_data;
   assign rsp_nmi_pulse       = rsp_ff.nmi_pulse;
   assign rsp_frame_done      = rsp_ff.frame_done;
   assign rsp_vram_we         = rsp_ff.vram_we;
   assign rsp_vram_byte_addr  = rsp_ff.vram_byte_addr;
   assign rsp_cgram_we        = rsp_ff.cgram_we;
   assign rsp_cgram_byte_addr = rsp_ff.cgram_byte_addr;
   assign rsp_mem_wdata       = rsp_ff.mem_wdata;

   // The skid stage is never full while the main stage is empty.
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage full while main stage is empty");

   // An interrupt pulse only goes out together with the frame pulse.
   a_nmi_with_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.nmi_pulse) |-> rsp_ff.frame_done)
      else $error("interrupt pulse without frame pulse");

   // One beat writes at most one of the two memories.
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.vram_we && rsp_ff.cgram_we))
      else $error("both memory write enables set");

   // The line counter stays inside the frame and the dot counter inside the line.
   a_counters: assert property (@(posedge clock) disable iff (reset)
      accept |=> (line_count_ff < LINES_C) && (dot_count_ff <= DOTS_C))
      else $error("timing counter out of range");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the video timing and VRAM port
// Drives ticks, register writes and status reads over the valid/stall request
// channel, predicts every response beat from its own copy of the counters and
// port state, and compares each response field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import vtvp_pkg::*;

   // Timing of the instance; the bench and the block share these values.
   localparam int DOTS_PER_LINE   = DOTS_PER_LINE_DEF;
   localparam int VBLANK_LINE     = VBLANK_LINE_DEF;
   localparam int LINES_PER_FRAME = LINES_PER_FRAME_DEF;

   // The command code that the block leaves unused.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Length of the long response hold, and the watchdog limit in cycles with
   // no beat accepted on either channel.
   localparam int LONG_HOLD  = 40;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 4;

   // The scoreboard keeps a private copy of the block's state. Each accepted
   // request beat advances that copy and queues the response it must cause;
   // each accepted response beat is matched against the oldest one queued.
   class timing_port_scoreboard;
      int dots_per_line;
      int vblank_line;
      int lines_per_frame;
      logic [CNT_W-1:0]   dot_cnt;
      logic [CNT_W-1:0]   line_cnt;
      bit                 vblank;
      bit                 nmi_en;
      logic [WADDR_W-1:0] word_addr;
      logic [7:0]         step;
      bit                 step_after_high;
      logic [PAL_W-1:0]   pal_addr;
      int                 mismatches;
      rsp_type            awaited_rsp[$];

      function new(int dpl, int vbl, int lpf);
         dots_per_line   = dpl;
         vblank_line     = vbl;
         lines_per_frame = lpf;
         dot_cnt         = '0;
         line_cnt        = '0;
         vblank          = 1'b0;
         nmi_en          = 1'b0;
         word_addr       = '0;
         step            = STEP_1;
         step_after_high = 1'b0;
         pal_addr        = '0;
         mismatches      = 0;
      endfunction

      function int awaited();
         return awaited_rsp.size();
      endfunction

      function void take_request(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
         rsp_type want;
         want = '0;
         case (cmd)
            CMD_TICK: begin
               // The line advances on the tick after the last dot of a line.
               if (dot_cnt == dots_per_line) begin
                  dot_cnt  = '0;
                  line_cnt = line_cnt + 1'b1;
                  if (line_cnt == vblank_line) begin
                     vblank          = 1'b1;
                     want.frame_done = 1'b1;
                     want.nmi_pulse  = nmi_en;
                  end
                  if (line_cnt == lines_per_frame) begin
                     vblank   = 1'b0;
                     line_cnt = '0;
                  end
               end
               dot_cnt = dot_cnt + 1'b1;
            end
            CMD_WRITE: begin
               case (addr)
                  ADDR_PORT_CTRL: begin
                     case (data[1:0])
                        STEP_SEL_1:  step = STEP_1;
                        STEP_SEL_32: step = STEP_32;
                        default:     step = STEP_128;
                     endcase
                     step_after_high = data[7];
                  end
                  ADDR_WADDR_LO: word_addr = {word_addr[14:8], data};
                  ADDR_WADDR_HI: word_addr = {data[6:0], word_addr[7:0]};
                  ADDR_VDATA_LO: begin
                     want.vram_we        = 1'b1;
                     want.vram_byte_addr = {word_addr, 1'b0};
                     want.mem_wdata      = data;
                     if (!step_after_high) word_addr = word_addr + {7'd0, step};
                  end
                  ADDR_VDATA_HI: begin
                     want.vram_we        = 1'b1;
                     want.vram_byte_addr = {word_addr, 1'b1};
                     want.mem_wdata      = data;
                     if (step_after_high) word_addr = word_addr + {7'd0, step};
                  end
                  ADDR_PAL_ADDR: pal_addr = {data, 1'b0};
                  ADDR_PAL_DATA: begin
                     want.cgram_we        = 1'b1;
                     want.cgram_byte_addr = pal_addr;
                     want.mem_wdata       = data;
                     pal_addr             = pal_addr + 1'b1;
                  end
                  ADDR_INT_EN: nmi_en = data[7];
                  default: ;
               endcase
            end
            CMD_READ: begin
               if (addr == ADDR_VBL_STAT) begin
                  want.read_data = (vblank ? STAT_VBLANK : 8'h00) |
                                   (addr[15:8] & OPEN_BUS_MASK);
               end else if (addr == ADDR_HV_STAT) begin
                  want.read_data = ((line_cnt >= vblank_line) ? STAT_VBLANK : 8'h00) |
                                   ((dot_cnt >= HBLANK_START || dot_cnt <= HBLANK_END) ?
                                    STAT_HBLANK : 8'h00);
               end
            end
            default: ; // The unused code changes nothing and answers with zeros.
         endcase
         awaited_rsp.push_back(want);
      endfunction

      function void check_field(string fname, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %h, actual %h", $time, fname, want, got);
            mismatches++;
         end
      endfunction

      function void match_response(rsp_type got);
         rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: response beat with nothing awaited, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = awaited_rsp.pop_front();
         check_field("read_data",       want.read_data,       got.read_data);
         check_field("nmi_pulse",       want.nmi_pulse,       got.nmi_pulse);
         check_field("frame_done",      want.frame_done,      got.frame_done);
         check_field("vram_we",         want.vram_we,         got.vram_we);
         check_field("vram_byte_addr",  want.vram_byte_addr,  got.vram_byte_addr);
         check_field("cgram_we",        want.cgram_we,        got.cgram_we);
         check_field("cgram_byte_addr", want.cgram_byte_addr, got.cgram_byte_addr);
         check_field("mem_wdata",       want.mem_wdata,       got.mem_wdata);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [15:0] req_bus_addr;
   logic [7:0]  req_wdata;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_read_data;
   logic        rsp_nmi_pulse;
   logic        rsp_frame_done;
   logic        rsp_vram_we;
   logic [15:0] rsp_vram_byte_addr;
   logic        rsp_cgram_we;
   logic [8:0]  rsp_cgram_byte_addr;
   logic [7:0]  rsp_mem_wdata;

   // Idling switches for each side, and the long-hold handshake between the
   // stimulus and the receiver process.
   bit req_idling = 1'b1;
   bit rsp_idling = 1'b1;
   int long_holds_asked = 0;
   int long_holds_done = 0;
   int quiet_cycles = 0;

   logic [15:0] write_regs [0:7] = '{ADDR_PORT_CTRL, ADDR_WADDR_LO, ADDR_WADDR_HI,
                                     ADDR_VDATA_LO, ADDR_VDATA_HI, ADDR_PAL_ADDR,
                                     ADDR_PAL_DATA, ADDR_INT_EN};

   timing_port_scoreboard sb = new(DOTS_PER_LINE, VBLANK_LINE, LINES_PER_FRAME);

   video_timing_and_vram_port #(
      .DOTS_PER_LINE   (DOTS_PER_LINE),
      .VBLANK_LINE     (VBLANK_LINE),
      .LINES_PER_FRAME (LINES_PER_FRAME)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_bus_addr        (req_bus_addr),
      .req_wdata           (req_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_data       (rsp_read_data),
      .rsp_nmi_pulse       (rsp_nmi_pulse),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_vram_we         (rsp_vram_we),
      .rsp_vram_byte_addr  (rsp_vram_byte_addr),
      .rsp_cgram_we        (rsp_cgram_we),
      .rsp_cgram_byte_addr (rsp_cgram_byte_addr),
      .rsp_mem_wdata       (rsp_mem_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one request beat and holds it until the block takes it. The task
   // is always entered at a rising edge, so a beat that follows an accepted
   // one keeps valid high without dropping it in between. A random idle gap
   // may come first while sender idling is on.
   task automatic send_beat(input logic [1:0] cmd, input logic [15:0] addr,
                            input logic [7:0] data);
      if (req_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_bus_addr <= addr;
      req_wdata    <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_request(cmd, addr, data);
   endtask

   task automatic reg_write(input logic [15:0] addr, input logic [7:0] data);
      send_beat(CMD_WRITE, addr, data);
   endtask

   task automatic status_read(input logic [15:0] addr);
      send_beat(CMD_READ, addr, 8'($urandom));
   endtask

   task automatic dot_tick();
      send_beat(CMD_TICK, 16'($urandom), 8'($urandom));
   endtask

   // Stops offering and waits until every awaited response has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.awaited() != 0) @(posedge clock);
   endtask

   // Mixed traffic: ticks, status reads, single register writes, well-formed
   // runs of address setup followed by data writes, and some noise with any
   // command code and any address.
   task automatic random_traffic(input int beats);
      int done;
      int r;
      int k;
      int len;
      done = 0;
      while (done < beats) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            dot_tick();
            done++;
         end else if (r < 45) begin
            status_read($urandom_range(0, 1) ? ADDR_VBL_STAT : ADDR_HV_STAT);
            done++;
         end else if (r < 80) begin
            reg_write(write_regs[$urandom_range(0, 7)], 8'($urandom));
            done++;
         end else if (r < 92) begin
            len = $urandom_range(2, 6);
            if ($urandom_range(0, 1)) begin
               reg_write(ADDR_PORT_CTRL, 8'($urandom));
               reg_write(ADDR_WADDR_LO, 8'($urandom));
               reg_write(ADDR_WADDR_HI, 8'($urandom));
               for (k = 0; k < len; k++)
                  reg_write(k[0] ? ADDR_VDATA_HI : ADDR_VDATA_LO, 8'($urandom));
               done += len + 3;
            end else begin
               reg_write(ADDR_PAL_ADDR, 8'($urandom));
               for (k = 0; k < len; k++) reg_write(ADDR_PAL_DATA, 8'($urandom));
               done += len + 1;
            end
         end else begin
            send_beat(2'($urandom), 16'($urandom), 8'($urandom));
            done++;
         end
      end
   endtask

   // The receiver stalls in random bursts while its idling is on. When the
   // stimulus asks for a long hold it keeps stall high for the long hold,
   // counted here, so the block fills and stalls input.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_holds_asked != long_holds_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            long_holds_done++;
         end else if (rsp_idling && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Response monitor: every beat taken by the bench is checked in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.match_response('{rsp_read_data, rsp_nmi_pulse, rsp_frame_done, rsp_vram_we,
                             rsp_vram_byte_addr, rsp_cgram_we, rsp_cgram_byte_addr,
                             rsp_mem_wdata});
      end
   end

   // Watchdog: the run ends if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int k;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_cmd      <= CMD_TICK;
      req_bus_addr <= '0;
      req_wdata    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Status reads straight after reset, where dot zero lies
      // inside the horizontal blank window.
      status_read(ADDR_VBL_STAT);
      status_read(ADDR_HV_STAT);
      reg_write(ADDR_INT_EN, 8'h80);
      // Word address at its top value: the low-byte write steps it past the
      // top of the 15-bit range, so the following high byte lands at word 0.
      reg_write(ADDR_PORT_CTRL, 8'h00);
      reg_write(ADDR_WADDR_LO, 8'hFF);
      reg_write(ADDR_WADDR_HI, 8'hFF);
      reg_write(ADDR_VDATA_LO, 8'hAA);
      reg_write(ADDR_VDATA_HI, 8'h55);
      // Step of 32 after the high byte, then 128 (both selector codes that
      // give it) after the low and after the high byte.
      reg_write(ADDR_PORT_CTRL, 8'h81);
      reg_write(ADDR_VDATA_LO, 8'h00);
      reg_write(ADDR_VDATA_HI, 8'hFF);
      reg_write(ADDR_PORT_CTRL, 8'h02);
      reg_write(ADDR_VDATA_LO, 8'h0F);
      reg_write(ADDR_PORT_CTRL, 8'hFF);
      reg_write(ADDR_VDATA_HI, 8'hF0);
      // Palette address at its top, so the third data write wraps to zero.
      reg_write(ADDR_PAL_ADDR, 8'hFF);
      for (k = 0; k < 3; k++) reg_write(ADDR_PAL_DATA, 8'h5A);
      // Unknown addresses, the unused command and a plain tick.
      status_read(16'hFFFF);
      reg_write(16'h0000, 8'hFF);
      send_beat(CMD_UNUSED, 16'hFFFF, 8'hFF);
      dot_tick();

      // Random part with idling on both sides.
      random_traffic(300);

      // The receiver holds off for a long stretch while beats keep coming, so
      // both response registers fill and the request side stalls.
      long_holds_asked++;
      random_traffic(20);

      // The sender pauses until everything is back, then carries on.
      wait_drained();
      random_traffic(30);

      // Last part of the run, with no idling on either side.
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      reg_write(ADDR_INT_EN, 8'h7F);
      random_traffic(30);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
